>>> rtl/bezier_easing_curve_eval_top_assert.svh
// assertion macros for the bezier easing curve evaluator
`ifndef BEZIER_EASING_CURVE_EVAL_TOP_ASSERT_SVH
`define BEZIER_EASING_CURVE_EVAL_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BECE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bece assertion failed");
`define BECE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bece assertion failed");
`else
`define BECE_ASSERT(lbl, clk, rst, prop)
`define BECE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/bece_pkg.sv
// types, constants and tables shared by the bezier easing curve evaluator
package bece_pkg;

   localparam int QB = 24;
   localparam int QW = 32;
   localparam int DIV_W = QW - 1 + QB;
   localparam int CTRL_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int TOL = 16;
   localparam int T_MAX = (1 << 25) - 1;
   localparam int T_MIN = -(1 << 25);
   localparam logic signed [QW-1:0] QONE = QW'(1 << QB);

   localparam logic [CSR_IDX_W-1:0] REG_CTRL1_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL1_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL2_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL2_Y = 2'd3;

   localparam logic [CTRL_W-1:0] CTRL1_X_RST = 7'd20;
   localparam logic [CTRL_W-1:0] CTRL1_Y_RST = 7'd20;
   localparam logic [CTRL_W-1:0] CTRL2_X_RST = 7'd107;
   localparam logic [CTRL_W-1:0] CTRL2_Y_RST = 7'd107;

   // 2^24 / 127 integer part, and reciprocal of 127 for the small remainder
   localparam int CTRL_SCALE = 132104;
   localparam int RECIP_127 = 1033;
   localparam int RECIP_SH = 17;

   localparam logic [2:0] A_IT = 3'd0;
   localparam logic [2:0] A_T  = 3'd1;
   localparam logic [2:0] A_RA = 3'd2;
   localparam logic [2:0] A_RB = 3'd3;
   localparam logic [2:0] A_RC = 3'd4;

   localparam logic [2:0] B_IT = 3'd0;
   localparam logic [2:0] B_T  = 3'd1;
   localparam logic [2:0] B_RA = 3'd2;
   localparam logic [2:0] B_RB = 3'd3;
   localparam logic [2:0] B_P1 = 3'd4;
   localparam logic [2:0] B_P2 = 3'd5;
   localparam logic [2:0] B_PD = 3'd6;
   localparam logic [2:0] B_PC = 3'd7;

   localparam logic [2:0] D_RA   = 3'd0;
   localparam logic [2:0] D_RB   = 3'd1;
   localparam logic [2:0] D_RC   = 3'd2;
   localparam logic [2:0] D_SET3 = 3'd3;
   localparam logic [2:0] D_ADD3 = 3'd4;
   localparam logic [2:0] D_ADD6 = 3'd5;
   localparam logic [2:0] D_ADD1 = 3'd6;

   localparam int MOP_W = 4;
   localparam logic [MOP_W-1:0] MOP_BEZ_FIRST = 4'd0;
   localparam logic [MOP_W-1:0] MOP_BEZ_LAST  = 4'd6;
   localparam logic [MOP_W-1:0] MOP_SLP_FIRST = 4'd7;
   localparam logic [MOP_W-1:0] MOP_SLP_LAST  = 4'd12;

   typedef struct packed {
      logic [2:0] asel;
      logic [2:0] bsel;
      logic [2:0] dst;
   } mop_type;

   typedef struct packed {
      logic             load;
      logic             mul_go;
      logic             mul_wb;
      logic [MOP_W-1:0] mop;
      logic             curve_y;
      logic             save_err;
      logic             div_start;
      logic             div_step;
      logic             newton_upd;
      logic             bis_init;
      logic             bis_upd;
      logic             t_clamp;
      logic             out_load;
   } cmd_type;

   typedef struct packed {
      logic err_small;
      logic slope_small;
   } sts_type;

   // multiply sequence: curve value, then slope
   function automatic mop_type mop_rom(input logic [MOP_W-1:0] idx);
      mop_type m;
      begin
         case (idx)
            4'd0:    m = '{asel: A_IT, bsel: B_IT, dst: D_RA};
            4'd1:    m = '{asel: A_T,  bsel: B_T,  dst: D_RB};
            4'd2:    m = '{asel: A_RA, bsel: B_T,  dst: D_RC};
            4'd3:    m = '{asel: A_RC, bsel: B_P1, dst: D_SET3};
            4'd4:    m = '{asel: A_IT, bsel: B_RB, dst: D_RC};
            4'd5:    m = '{asel: A_RC, bsel: B_P2, dst: D_ADD3};
            4'd6:    m = '{asel: A_RB, bsel: B_T,  dst: D_ADD1};
            4'd7:    m = '{asel: A_IT, bsel: B_IT, dst: D_RA};
            4'd8:    m = '{asel: A_RA, bsel: B_P1, dst: D_SET3};
            4'd9:    m = '{asel: A_IT, bsel: B_T,  dst: D_RA};
            4'd10:   m = '{asel: A_RA, bsel: B_PD, dst: D_ADD6};
            4'd11:   m = '{asel: A_T,  bsel: B_T,  dst: D_RA};
            4'd12:   m = '{asel: A_RA, bsel: B_PC, dst: D_ADD3};
            default: m = '{asel: A_T,  bsel: B_T,  dst: D_RA};
         endcase
         return m;
      end
   endfunction

   // control point c to Q24: floor((c * 2^24 + 63) / 127)
   function automatic logic signed [QW-1:0] ctrl_to_q(input logic [CTRL_W-1:0] c);
      logic [10:0] n;
      logic [21:0] prod;
      logic [QW-1:0] whole;
      begin
         n = {1'b0, c, 3'b000} + 11'd63;
         prod = 22'(n) * 22'(RECIP_127);
         whole = QW'(c) * QW'(CTRL_SCALE);
         return signed'(whole + QW'(prod >> RECIP_SH));
      end
   endfunction

endpackage

>>> rtl/bece_req_if.sv
// request channel: progress value in, clamped to 0..1 by the datapath
interface bece_req_if #(parameter int XW = 18);
   logic                 valid;
   logic                 ready;
   logic signed [XW-1:0] x_in;
   modport source(output valid, output x_in, input ready);
   modport sink(input valid, input x_in, output ready);
endinterface

>>> rtl/bece_rsp_if.sv
// response channel: eased value out
interface bece_rsp_if #(parameter int YW = 17);
   logic          valid;
   logic          ready;
   logic [YW-1:0] y_out;
   modport source(output valid, output y_out, input ready);
   modport sink(input valid, input y_out, output ready);
endinterface

>>> rtl/bece_ctrl.sv
// solver sequencer: newton, bisection and output evaluation
`include "bezier_easing_curve_eval_top_assert.svh"
module bece_ctrl import bece_pkg::*; #(
   parameter int NEWTON_STEPS = 8,
   parameter int BISECT_STEPS = 24
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam int ITMAX = (NEWTON_STEPS > BISECT_STEPS) ? NEWTON_STEPS : BISECT_STEPS;
   localparam int ITW = $clog2(ITMAX + 1);
   localparam int DCW = $clog2(DIV_W);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_N_EVAL  = 4'd1;
   localparam logic [3:0] S_N_CHK   = 4'd2;
   localparam logic [3:0] S_N_SLOPE = 4'd3;
   localparam logic [3:0] S_N_SCHK  = 4'd4;
   localparam logic [3:0] S_N_DIV   = 4'd5;
   localparam logic [3:0] S_N_UPD   = 4'd6;
   localparam logic [3:0] S_B_INIT  = 4'd7;
   localparam logic [3:0] S_B_EVAL  = 4'd8;
   localparam logic [3:0] S_B_CHK   = 4'd9;
   localparam logic [3:0] S_Y_CLAMP = 4'd10;
   localparam logic [3:0] S_Y_EVAL  = 4'd11;
   localparam logic [3:0] S_DONE    = 4'd12;

   logic [3:0]       state_ff, state_in;
   logic [MOP_W-1:0] mop_ff, mop_in;
   logic             phase_ff, phase_in;
   logic [ITW-1:0]   iter_ff, iter_in;
   logic [DCW-1:0]   div_cnt_ff, div_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [MOP_W-1:0] mop_last;
   logic [3:0]       eval_next;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      mop_last = (state_ff == S_N_SLOPE) ? MOP_SLP_LAST : MOP_BEZ_LAST;
      case (state_ff)
         S_N_EVAL:  eval_next = S_N_CHK;
         S_N_SLOPE: eval_next = S_N_SCHK;
         S_B_EVAL:  eval_next = S_B_CHK;
         default:   eval_next = S_DONE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mop = mop_ff;
      cmd.curve_y = (state_ff == S_Y_EVAL);
      state_in = state_ff;
      mop_in = mop_ff;
      phase_in = phase_ff;
      iter_in = iter_ff;
      div_cnt_in = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               mop_in = MOP_BEZ_FIRST;
               phase_in = 1'b0;
               iter_in = '0;
               state_in = S_N_EVAL;
            end
         end
         S_N_EVAL, S_N_SLOPE, S_B_EVAL, S_Y_EVAL: begin
            if (!phase_ff) begin
               cmd.mul_go = 1'b1;
               phase_in = 1'b1;
            end else begin
               cmd.mul_wb = 1'b1;
               phase_in = 1'b0;
               if (mop_ff == mop_last) begin
                  state_in = eval_next;
               end else begin
                  mop_in = mop_ff + 1'b1;
               end
            end
         end
         S_N_CHK: begin
            if (sts.err_small) begin
               state_in = S_Y_CLAMP;
            end else begin
               cmd.save_err = 1'b1;
               mop_in = MOP_SLP_FIRST;
               state_in = S_N_SLOPE;
            end
         end
         S_N_SCHK: begin
            if (sts.slope_small) begin
               state_in = S_B_INIT;
            end else begin
               cmd.div_start = 1'b1;
               div_cnt_in = '0;
               state_in = S_N_DIV;
            end
         end
         S_N_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DCW'(DIV_W - 1)) begin
               state_in = S_N_UPD;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_N_UPD: begin
            cmd.newton_upd = 1'b1;
            mop_in = MOP_BEZ_FIRST;
            if (iter_ff == ITW'(NEWTON_STEPS - 1)) begin
               state_in = S_B_INIT;
            end else begin
               iter_in = iter_ff + 1'b1;
               state_in = S_N_EVAL;
            end
         end
         S_B_INIT: begin
            cmd.bis_init = 1'b1;
            iter_in = '0;
            mop_in = MOP_BEZ_FIRST;
            state_in = S_B_EVAL;
         end
         S_B_CHK: begin
            mop_in = MOP_BEZ_FIRST;
            if (sts.err_small) begin
               state_in = S_Y_CLAMP;
            end else begin
               cmd.bis_upd = 1'b1;
               if (iter_ff == ITW'(BISECT_STEPS - 1)) begin
                  state_in = S_Y_CLAMP;
               end else begin
                  iter_in = iter_ff + 1'b1;
                  state_in = S_B_EVAL;
               end
            end
         end
         S_Y_CLAMP: begin
            cmd.t_clamp = 1'b1;
            mop_in = MOP_BEZ_FIRST;
            state_in = S_Y_EVAL;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mop_ff <= MOP_BEZ_FIRST;
         phase_ff <= 1'b0;
         iter_ff <= '0;
         div_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mop_ff <= mop_in;
         phase_ff <= phase_in;
         iter_ff <= iter_in;
         div_cnt_ff <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BECE_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
   `BECE_ASSERT(a_bis_bound, clock, reset, (state_ff == S_B_CHK) |-> (iter_ff < ITW'(BISECT_STEPS)))
   `BECE_ASSERT(a_div_len, clock, reset, (state_ff == S_N_UPD) |-> ($past(div_cnt_ff) == DCW'(DIV_W - 1)))
   `BECE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && !rsp_valid_ff))

endmodule

>>> rtl/bece_dp.sv
// datapath: control registers, shared multiplier, divider and solver registers
module bece_dp import bece_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CTRL_W-1:0]          csr_wdata,
   input  logic signed [FRAC_BITS+1:0] x_in,
   output logic [FRAC_BITS:0]         y_out,
   input  cmd_type                    cmd,
   output sts_type                    sts
);

   localparam int SH = QB - FRAC_BITS;
   localparam int EW = DIV_W + 2;
   localparam logic [QW-1:0] RND = (SH > 0) ? (QW'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;
   localparam logic [FRAC_BITS:0] XONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [2*QW-1:0] MUL_HALF = (2*QW)'(1) << (QB - 1);
   localparam logic signed [QW-1:0] TOL_Q = QW'(TOL);
   localparam logic signed [EW-1:0] TMAX_E = EW'(T_MAX);
   localparam logic signed [EW-1:0] TMIN_E = EW'(T_MIN);

   logic [CTRL_W-1:0] c1x_ff, c1y_ff, c2x_ff, c2y_ff;

   logic signed [QW-1:0]   xq_ff, xq_in, t_ff, t_in, lft_ff, lft_in, rgt_ff, rgt_in;
   logic signed [QW-1:0]   ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in;
   logic signed [QW-1:0]   acc_ff, acc_in, err_ff, err_in;
   logic signed [2*QW-1:0] mul_ff, mul_in;
   logic [QW-1:0]          rem_ff, rem_in, den_ff, den_in;
   logic [DIV_W-1:0]       quo_ff, quo_in;
   logic                   neg_ff, neg_in;
   logic [FRAC_BITS:0]     y_ff, y_in;

   logic signed [QW-1:0]   p1, p2, pd, pc, it, a_op, b_op, wb, err, nl, nr, yc;
   logic signed [2*QW-1:0] rnd;
   logic [QW:0]            rem_sh, rem_diff, mid_sum;
   logic [QW-1:0]          err_mag, den_mag, ysum, yv;
   logic signed [EW-1:0]   q_ext, q_sgn, t_new;
   logic [FRAC_BITS:0]     xc;
   logic                   err_neg, rem_ok;
   mop_type                mop;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1x_ff <= CTRL1_X_RST;
         c1y_ff <= CTRL1_Y_RST;
         c2x_ff <= CTRL2_X_RST;
         c2y_ff <= CTRL2_Y_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_CTRL1_X: c1x_ff <= csr_wdata;
            REG_CTRL1_Y: c1y_ff <= csr_wdata;
            REG_CTRL2_X: c2x_ff <= csr_wdata;
            REG_CTRL2_Y: c2y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      p1 = cmd.curve_y ? ctrl_to_q(c1y_ff) : ctrl_to_q(c1x_ff);
      p2 = cmd.curve_y ? ctrl_to_q(c2y_ff) : ctrl_to_q(c2x_ff);
      pd = p2 - p1;
      pc = QONE - p2;
      it = QONE - t_ff;
      mop = mop_rom(cmd.mop);
      case (mop.asel)
         A_IT:    a_op = it;
         A_T:     a_op = t_ff;
         A_RA:    a_op = ra_ff;
         A_RB:    a_op = rb_ff;
         A_RC:    a_op = rc_ff;
         default: a_op = t_ff;
      endcase
      case (mop.bsel)
         B_IT:    b_op = it;
         B_T:     b_op = t_ff;
         B_RA:    b_op = ra_ff;
         B_RB:    b_op = rb_ff;
         B_P1:    b_op = p1;
         B_P2:    b_op = p2;
         B_PD:    b_op = pd;
         B_PC:    b_op = pc;
         default: b_op = t_ff;
      endcase
      rnd = (mul_ff + MUL_HALF) >>> QB;
      wb = rnd[QW-1:0];

      err = acc_ff - xq_ff;
      err_neg = (acc_ff < xq_ff);
      sts.err_small = (err > -TOL_Q) && (err < TOL_Q);
      sts.slope_small = (acc_ff > -TOL_Q) && (acc_ff < TOL_Q);

      err_mag = err_ff[QW-1] ? QW'(-err_ff) : QW'(err_ff);
      den_mag = acc_ff[QW-1] ? QW'(-acc_ff) : QW'(acc_ff);
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      rem_ok = (rem_sh >= {1'b0, den_ff});
      rem_diff = rem_sh - {1'b0, den_ff};

      q_ext = signed'({2'b00, quo_ff});
      q_sgn = neg_ff ? -q_ext : q_ext;
      t_new = {{(EW-QW){t_ff[QW-1]}}, t_ff} - q_sgn;

      nl = err_neg ? t_ff : lft_ff;
      nr = err_neg ? rgt_ff : t_ff;
      mid_sum = {nl[QW-1], nl} + {nr[QW-1], nr};

      if (x_in[FRAC_BITS+1]) begin
         xc = '0;
      end else if (x_in[FRAC_BITS:0] > XONE) begin
         xc = XONE;
      end else begin
         xc = x_in[FRAC_BITS:0];
      end

      if (acc_ff < 0) begin
         yc = '0;
      end else if (acc_ff > QONE) begin
         yc = QONE;
      end else begin
         yc = acc_ff;
      end
      ysum = QW'(yc) + RND;
      yv = ysum >> SH;
   end

   always_comb begin
      xq_in = xq_ff;
      t_in = t_ff;
      lft_in = lft_ff;
      rgt_in = rgt_ff;
      ra_in = ra_ff;
      rb_in = rb_ff;
      rc_in = rc_ff;
      acc_in = acc_ff;
      err_in = err_ff;
      mul_in = mul_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      y_in = y_ff;
      if (cmd.load) begin
         xq_in = signed'(QW'(xc) << SH);
         t_in = signed'(QW'(xc) << SH);
      end
      if (cmd.mul_go) begin
         mul_in = a_op * b_op;
      end
      if (cmd.mul_wb) begin
         case (mop.dst)
            D_RA:    ra_in = wb;
            D_RB:    rb_in = wb;
            D_RC:    rc_in = wb;
            D_SET3:  acc_in = 3 * wb;
            D_ADD3:  acc_in = acc_ff + 3 * wb;
            D_ADD6:  acc_in = acc_ff + 6 * wb;
            D_ADD1:  acc_in = acc_ff + wb;
            default: ra_in = wb;
         endcase
      end
      if (cmd.save_err) begin
         err_in = err;
      end
      if (cmd.div_start) begin
         rem_in = '0;
         den_in = den_mag;
         quo_in = {err_mag[QW-2:0], {QB{1'b0}}};
         neg_in = err_ff[QW-1] ^ acc_ff[QW-1];
      end
      if (cmd.div_step) begin
         rem_in = rem_ok ? rem_diff[QW-1:0] : rem_sh[QW-1:0];
         quo_in = {quo_ff[DIV_W-2:0], rem_ok};
      end
      if (cmd.newton_upd) begin
         if (t_new > TMAX_E) begin
            t_in = TMAX_E[QW-1:0];
         end else if (t_new < TMIN_E) begin
            t_in = TMIN_E[QW-1:0];
         end else begin
            t_in = t_new[QW-1:0];
         end
      end
      if (cmd.bis_init) begin
         t_in = xq_ff;
         lft_in = '0;
         rgt_in = QONE;
      end
      if (cmd.bis_upd) begin
         lft_in = nl;
         rgt_in = nr;
         t_in = mid_sum[QW:1];
      end
      if (cmd.t_clamp) begin
         if (t_ff < 0) begin
            t_in = '0;
         end else if (t_ff > QONE) begin
            t_in = QONE;
         end
      end
      if (cmd.out_load) begin
         y_in = yv[FRAC_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      xq_ff <= xq_in;
      t_ff <= t_in;
      lft_ff <= lft_in;
      rgt_ff <= rgt_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      rc_ff <= rc_in;
      acc_ff <= acc_in;
      err_ff <= err_in;
      mul_ff <= mul_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      y_ff <= y_in;
   end

   assign y_out = y_ff;

endmodule

>>> rtl/bezier_easing_curve_eval_top.sv
// top level of the cubic bezier easing curve evaluator
// Usage: program the two inner control points through the csr write port
// (index 0..3: ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, 7 bits each, v/127),
// only while the block is idle. Each request beat carries x_in in signed
// Q2.FRAC_BITS; it is clamped to 0..1 and the block answers with one
// response beat holding y_out = By(t) where Bx(t) = x, unsigned Q1.FRAC_BITS.
// One item is solved at a time on a shared 32x32 multiplier (seven
// products per curve value, six per slope) and a one-bit-per-cycle
// 55-step divider for each newton step. A new request is taken only
// in the idle state, after the previous result is loaded into the
// output register. A finished result sits in the output register while
// the next request is taken; a stalled receiver holds the block only at
// the end of the next item. Reset loads the default control points,
// empties the output register and returns to idle.
module bezier_easing_curve_eval_top import bece_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int NEWTON_STEPS = 8,
   parameter int BISECT_STEPS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CTRL_W-1:0]    csr_wdata,
   bece_req_if.sink             req_chan,
   bece_rsp_if.source           rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   bece_ctrl #(
      .NEWTON_STEPS(NEWTON_STEPS),
      .BISECT_STEPS(BISECT_STEPS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .rsp_ready(rsp_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .cmd(cmd),
      .sts(sts)
   );

   bece_dp #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .x_in(req_chan.x_in),
      .y_out(rsp_chan.y_out),
      .cmd(cmd),
      .sts(sts)
   );

endmodule

>>> tb/bezier_easing_curve_eval_top_tb.sv
// testbench for the cubic bezier easing curve evaluator: directed table, random x, own predictor
module bezier_easing_curve_eval_top_tb;
   import bece_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int XW = 18;
   localparam int YW = 17;
   localparam longint ONE_Q = 64'sd1 << 24;
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int DRAIN_CYCLES = 1100;

   typedef struct {
      logic signed [XW-1:0] x;
      bit                   known;
      logic [YW-1:0]        y;
   } x_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CTRL_W-1:0] csr_wdata;

   bece_req_if #(.XW(XW)) req_chan();
   bece_rsp_if #(.YW(YW)) rsp_chan();

   bezier_easing_curve_eval_top dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   logic [CTRL_W-1:0] ctrl_pt [4];
   logic [YW-1:0] y_pending [$];
   int fail_count = 0;
   int cycle_count = 0;
   int burst_left = 0;

   x_row_type x_table [] = '{
      '{18'sh20000, 1'b1, 17'd0},
      '{-18'sd1, 1'b1, 17'd0},
      '{18'sd0, 1'b1, 17'd0},
      '{18'sd65536, 1'b1, 17'd65536},
      '{18'sd65537, 1'b1, 17'd65536},
      '{18'sd131071, 1'b1, 17'd65536},
      '{18'sd1, 1'b0, 17'd0},
      '{18'sd2, 1'b0, 17'd0},
      '{18'sd16, 1'b0, 17'd0},
      '{18'sd4096, 1'b0, 17'd0},
      '{18'sd16384, 1'b0, 17'd0},
      '{18'sd32767, 1'b0, 17'd0},
      '{18'sd32768, 1'b0, 17'd0},
      '{18'sd49152, 1'b0, 17'd0},
      '{18'sd65280, 1'b0, 17'd0},
      '{18'sd65535, 1'b0, 17'd0},
      '{18'sh2AAAA, 1'b0, 17'd0},
      '{18'sh15555, 1'b0, 17'd0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint mul_q24(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 23)) >>> 24;
   endfunction

   function automatic longint pt_to_q24(input logic [CTRL_W-1:0] c);
      return ((longint'(c) <<< 24) + 63) / 127;
   endfunction

   function automatic longint clamp_unit(input longint v);
      if (v < 0) return 0;
      if (v > ONE_Q) return ONE_Q;
      return v;
   endfunction

   function automatic longint curve_at(input longint p1, input longint p2, input longint t);
      longint it, a, b;
      it = ONE_Q - t;
      a = mul_q24(it, it);
      b = mul_q24(t, t);
      return 3 * mul_q24(mul_q24(a, t), p1) + 3 * mul_q24(mul_q24(it, b), p2) + mul_q24(b, t);
   endfunction

   function automatic longint curve_slope(input longint p1, input longint p2, input longint t);
      longint it;
      it = ONE_Q - t;
      return 3 * mul_q24(mul_q24(it, it), p1) + 6 * mul_q24(mul_q24(it, t), p2 - p1)
           + 3 * mul_q24(mul_q24(t, t), ONE_Q - p2);
   endfunction

   function automatic longint solve_param(input longint x, input longint p1, input longint p2);
      longint t, lo, hi, err, slope, cur;
      t = x;
      lo = 0;
      hi = ONE_Q;
      for (int i = 0; i < 8; i++) begin
         err = curve_at(p1, p2, t) - x;
         if ((err < 0 ? -err : err) < TOL) return clamp_unit(t);
         slope = curve_slope(p1, p2, t);
         if ((slope < 0 ? -slope : slope) < TOL) break;
         t = t - (err * ONE_Q) / slope;
         if (t > T_MAX) t = T_MAX;
         if (t < T_MIN) t = T_MIN;
      end
      t = x;
      for (int i = 0; i < 24; i++) begin
         cur = curve_at(p1, p2, t);
         if ((cur - x < 0 ? x - cur : cur - x) < TOL) break;
         if (cur < x) lo = t;
         else hi = t;
         t = (lo + hi) >>> 1;
      end
      return clamp_unit(t);
   endfunction

   function automatic logic [YW-1:0] eased_value(input logic signed [XW-1:0] x_raw);
      longint xv, t, y;
      xv = longint'(x_raw);
      if (xv < 0) xv = 0;
      if (xv > 65536) xv = 65536;
      t = solve_param(xv <<< 8, pt_to_q24(ctrl_pt[REG_CTRL1_X]), pt_to_q24(ctrl_pt[REG_CTRL2_X]));
      y = clamp_unit(curve_at(pt_to_q24(ctrl_pt[REG_CTRL1_Y]), pt_to_q24(ctrl_pt[REG_CTRL2_Y]), t));
      y = (y + 128) >>> 8;
      if (y > 65536) y = 65536;
      return YW'(y);
   endfunction

   task automatic queue_y(input logic [YW-1:0] y);
      y_pending.insert(y_pending.size(), y);
   endtask

   task automatic write_pt(input logic [CSR_IDX_W-1:0] idx, input logic [CTRL_W-1:0] v);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      ctrl_pt[idx] = v;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_points(input logic [CTRL_W-1:0] a, input logic [CTRL_W-1:0] b,
                             input logic [CTRL_W-1:0] c, input logic [CTRL_W-1:0] d);
      write_pt(REG_CTRL1_X, a);
      write_pt(REG_CTRL1_Y, b);
      write_pt(REG_CTRL2_X, c);
      write_pt(REG_CTRL2_Y, d);
   endtask

   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (y_pending.size() != 0) @(negedge clock);
   endtask

   // called at a falling edge; returns at the falling edge after the beat, or later after a random idle gap
   task automatic send_x(input logic signed [XW-1:0] x, input bit known,
                         input logic [YW-1:0] y_known);
      req_chan.valid = 1'b1;
      req_chan.x_in = x;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (known) queue_y(y_known);
      else queue_y(eased_value(x));
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_chan.valid = 1'b0;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 40)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      end
   endtask

   function automatic logic signed [XW-1:0] random_x();
      case ($urandom_range(0, 9))
         0: return XW'($urandom);
         1: return XW'($urandom_range(0, 64));
         2: return XW'($urandom_range(65470, 65536));
         default: return XW'($urandom_range(0, 65536));
      endcase
   endfunction

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         int mode, len;
         mode = $urandom_range(0, 3);
         len = $urandom_range(10, 300);
         repeat (len) begin
            @(negedge clock);
            case (mode)
               0: rsp_chan.ready = 1'b1;
               1: rsp_chan.ready = 1'($urandom_range(0, 1));
               2: rsp_chan.ready = ($urandom_range(0, 9) == 0);
               default: rsp_chan.ready = ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (y_pending.size() == 0) begin
            $error("unexpected beat y_out: actual %0d", rsp_chan.y_out);
            fail_count++;
         end else begin
            logic [YW-1:0] want;
            want = y_pending.pop_front();
            if (rsp_chan.y_out !== want) begin
               $error("y_out mismatch: expected %0d actual %0d", want, rsp_chan.y_out);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** bezier_easing_curve_eval_top: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [CTRL_W-1:0] pts [6][4];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.x_in = '0;
      ctrl_pt[REG_CTRL1_X] = CTRL1_X_RST;
      ctrl_pt[REG_CTRL1_Y] = CTRL1_Y_RST;
      ctrl_pt[REG_CTRL2_X] = CTRL2_X_RST;
      ctrl_pt[REG_CTRL2_Y] = CTRL2_Y_RST;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (x_table[i]) send_x(x_table[i].x, x_table[i].known, x_table[i].y);
      wait_drained();

      pts = '{'{7'd0, 7'd0, 7'd0, 7'd0}, '{7'd127, 7'd127, 7'd127, 7'd127},
              '{7'd127, 7'd0, 7'd0, 7'd127}, '{7'd0, 7'd127, 7'd127, 7'd0},
              '{7'd0, 7'd0, 7'd127, 7'd127}, '{7'd64, 7'd127, 7'd64, 7'd0}};
      for (int ph = 0; ph < 10; ph++) begin
         if (ph < 6) set_points(pts[ph][0], pts[ph][1], pts[ph][2], pts[ph][3]);
         else set_points(CTRL_W'($urandom), CTRL_W'($urandom),
                         CTRL_W'($urandom), CTRL_W'($urandom));
         for (int n = 0; n < 150; n++) begin
            if (n == 75 && ph[0]) wait_drained();
            send_x(random_x(), 1'b0, '0);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && y_pending.size() == 0)
         $display("** bezier_easing_curve_eval_top: PASSED **");
      else
         $display("** bezier_easing_curve_eval_top: FAILED **");
      $finish;
   end

endmodule

>>> bezier_easing_curve_eval_top.f
+incdir+rtl
rtl/bece_pkg.sv
rtl/bece_req_if.sv
rtl/bece_rsp_if.sv
rtl/bece_ctrl.sv
rtl/bece_dp.sv
rtl/bezier_easing_curve_eval_top.sv
tb/bezier_easing_curve_eval_top_tb.sv
